### src/stbs_pkg.sv
`timescale 1ns / 1ps

package stbs_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 10;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 11;

    // Default table size.
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Operation codes carried on the operation port.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Search sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_CMP  = 3'b100
    } state_t;

endpackage

### src/sorted_table_binary_search_core.sv
`timescale 1ns / 1ps
// Operation: a write transaction is stored at its accepting edge and gives no result; a
// search makes at most floor(log2(min(entry_count, TABLE_DEPTH)))+1 probes and strobes
// done on a match, or with found low once the search range is empty.
// Throughput: writes every cycle while idle; each probe is a table read, then a compare,
// so busy stays high for the whole search. The receiver cannot stall: done lasts one cycle.
// Reset: rst_n clears the sequencer, the strobe and entry_count; the table is not cleared.

module sorted_table_binary_search_core
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      operation,
    input  logic [INDEX_W-1:0]        index,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      done,
    output logic                      found,
    output logic [POS_W-1:0]          position,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [COUNT_W-1:0]        cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    state_t                    state_reg, state_next;
    logic [COUNT_W-1:0]        entry_count_reg;
    logic [COUNT_W-1:0]        lo_reg, lo_next;
    logic [COUNT_W-1:0]        hi_reg, hi_next;
    logic [COUNT_W-1:0]        mid_reg, mid_next;
    logic [COUNT_W-1:0]        hi_start;
    logic signed [DATA_W-1:0]  key_reg, key_next;
    logic                      done_reg, done_next;
    logic                      found_reg, found_next;
    logic [POS_W-1:0]          position_reg, position_next;
    logic                      accept;
    logic                      wr_en;
    logic                      rd_en;
    logic [DATA_W-1:0]         rd_data;
    logic                      range_open;
    logic                      entry_eq;
    logic                      entry_lt;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign found     = found_reg;
    assign position  = position_reg;

    // Table writes happen on acceptance, only for positions inside the table.
    assign wr_en = accept && (operation == OP_WRITE)
                   && (32'(index) < 32'(TABLE_DEPTH));

    // Upper bound of the search, saturated at the table size.
    assign hi_start = (32'(entry_count_reg) > 32'(TABLE_DEPTH))
                      ? COUNT_W'(TABLE_DEPTH) : entry_count_reg;

    // Probe point, rounded down towards the lower bound.
    assign range_open = (lo_reg < hi_reg);
    assign mid_next   = lo_reg + ((hi_reg - lo_reg - COUNT_W'(1)) >> 1);
    assign rd_en      = (state_reg == S_CALC) && range_open;

    // Compare the fetched entry against the key.
    assign entry_eq = ($signed(rd_data) == key_reg);
    assign entry_lt = ($signed(rd_data) < key_reg);

    stbs_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(index)),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(mid_next)),
        .rd_data (rd_data)
    );

    // Search sequencer.
    always_comb
    begin
        state_next    = state_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        key_next      = key_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        position_next = position_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == OP_SEARCH))
                begin
                    lo_next    = '0;
                    hi_next    = hi_start;
                    key_next   = value;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (!range_open)
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b0;
                    position_next = '0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (entry_eq)
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b1;
                    position_next = POS_W'(mid_reg);
                    state_next    = S_IDLE;
                end
                else
                begin
                    if (entry_lt)
                    begin
                        lo_next = mid_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                    state_next = S_CALC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                entry_count_reg <= cfg_data;
            end
        end
    end

    // Search bounds, key and result payload.
    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        key_reg      <= key_next;
        found_reg    <= found_next;
        position_reg <= position_next;
        if (rd_en)
        begin
            mid_reg <= mid_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A result is only strobed once the sequencer has returned to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobed while search still running");

    // A compare cycle always follows a read of a non-empty range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (lo_reg < hi_reg) && (mid_reg >= lo_reg)
                                 && (mid_reg < hi_reg))
        else $error("probe outside the search range");

    // The search never reaches beyond the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (32'(hi_reg) <= 32'(TABLE_DEPTH)))
        else $error("search bound beyond table depth");

    // A match lies below the entry count in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (32'(position_reg) < 32'(entry_count_reg)))
        else $error("match position outside searched entries");

    // The result strobe lasts a single cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");
`endif

endmodule

### src/stbs_ram.sv
`timescale 1ns / 1ps

module stbs_ram
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [TABLE_DEPTH];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import stbs_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int N_DIRECTED = 21;
    localparam int N_PHASES = 11;
    localparam int PHASE_ITEMS = 62;
    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

    typedef enum logic {
        ROW_CONFIG,
        ROW_ITEM
    } row_kind_t;

    // One line of the directed table. A configuration row carries the new
    // entry count in the low bits of val. Where typed is set, hit and pos
    // hold the answer that is expected; otherwise the lookup model decides.
    typedef struct packed {
        row_kind_t             kind;
        logic                  op;
        logic [INDEX_W-1:0]    idx;
        logic [DATA_W-1:0]     val;
        logic                  typed;
        logic                  hit;
        logic [POS_W-1:0]      pos;
    } stim_row_t;

    typedef struct {
        logic             hit;
        logic [POS_W-1:0] pos;
    } answer_t;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // Empty table after reset: nothing can be found.
        '{ROW_ITEM,   OP_SEARCH, 10'd0,    32'h0000_0000, 1'b1, 1'b0, 10'd0},
        '{ROW_ITEM,   OP_SEARCH, 10'd1023, 32'h7fff_ffff, 1'b1, 1'b0, 10'd0},
        // Five sorted entries spanning both extremes, plus the top index.
        '{ROW_ITEM,   OP_WRITE,  10'd0,    32'h8000_0000, 1'b0, 1'b0, 10'd0},
        '{ROW_ITEM,   OP_WRITE,  10'd1,    32'hffff_fffb, 1'b0, 1'b0, 10'd0},
        '{ROW_ITEM,   OP_WRITE,  10'd2,    32'h0000_0000, 1'b0, 1'b0, 10'd0},
        '{ROW_ITEM,   OP_WRITE,  10'd3,    32'h0000_0007, 1'b0, 1'b0, 10'd0},
        '{ROW_ITEM,   OP_WRITE,  10'd4,    32'h7fff_ffff, 1'b0, 1'b0, 10'd0},
        '{ROW_ITEM,   OP_WRITE,  10'd1023, 32'h5555_5555, 1'b0, 1'b0, 10'd0},
        '{ROW_CONFIG, OP_WRITE,  10'd0,    32'd5,         1'b0, 1'b0, 10'd0},
        '{ROW_ITEM,   OP_SEARCH, 10'd0,    32'h8000_0000, 1'b1, 1'b1, 10'd0},
        '{ROW_ITEM,   OP_SEARCH, 10'd0,    32'h7fff_ffff, 1'b1, 1'b1, 10'd4},
        '{ROW_ITEM,   OP_SEARCH, 10'd0,    32'h0000_0000, 1'b1, 1'b1, 10'd2},
        '{ROW_ITEM,   OP_SEARCH, 10'd0,    32'h0000_0003, 1'b0, 1'b0, 10'd0},
        '{ROW_ITEM,   OP_SEARCH, 10'd0,    32'hffff_fffa, 1'b0, 1'b0, 10'd0},
        // Break the ordering: the present key 7 is passed over by the probes.
        '{ROW_ITEM,   OP_WRITE,  10'd2,    32'h0000_0009, 1'b0, 1'b0, 10'd0},
        '{ROW_ITEM,   OP_SEARCH, 10'd0,    32'h0000_0007, 1'b0, 1'b0, 10'd0},
        // A single entry in use.
        '{ROW_CONFIG, OP_WRITE,  10'd0,    32'd1,         1'b0, 1'b0, 10'd0},
        '{ROW_ITEM,   OP_SEARCH, 10'd0,    32'h8000_0000, 1'b1, 1'b1, 10'd0},
        '{ROW_ITEM,   OP_SEARCH, 10'd0,    32'haaaa_aaaa, 1'b0, 1'b0, 10'd0},
        // Zero entries in use again: a stored key is not found.
        '{ROW_CONFIG, OP_WRITE,  10'd0,    32'd0,         1'b0, 1'b0, 10'd0},
        '{ROW_ITEM,   OP_SEARCH, 10'd0,    32'hffff_fffb, 1'b1, 1'b0, 10'd0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      operation = OP_WRITE;
    logic [INDEX_W-1:0]        index = '0;
    logic signed [DATA_W-1:0]  value = '0;
    logic                      done;
    logic                      found;
    logic [POS_W-1:0]          position;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [COUNT_W-1:0]        cfg_data = '0;

    // Shadow copy of the table and the entry count.
    logic signed [DATA_W-1:0]  shadow_entries [DEPTH];
    logic [COUNT_W-1:0]        shadow_count = '0;

    answer_t                   pending_answers [$];
    answer_t                   want;
    int                        mismatch_count = 0;
    bit                        idling_on = 1'b1;

    sorted_table_binary_search_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .index     (index),
        .value     (value),
        .done      (done),
        .found     (found),
        .position  (position),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Binary search over the shadow table, probing low + (high - 1 - low) / 2.
    function automatic answer_t lookup_key(input logic signed [DATA_W-1:0] key);
        answer_t ans;
        int      lo;
        int      hi;
        int      mid;
        ans.hit = 1'b0;
        ans.pos = '0;
        lo = 0;
        hi = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
        while (lo < hi && !ans.hit)
        begin
            mid = lo + (hi - 1 - lo) / 2;
            if (shadow_entries[mid] == key)
            begin
                ans.hit = 1'b1;
                ans.pos = POS_W'(mid);
            end
            else if (shadow_entries[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return ans;
    endfunction

    // A value that keeps entry i in order with its neighbours.
    function automatic logic signed [DATA_W-1:0] value_between(input int i);
        longint lo;
        longint hi;
        longint span;
        lo = (i == 0) ? longint'(MOST_NEG) : longint'(shadow_entries[i-1]);
        hi = (i == DEPTH - 1) ? longint'(MOST_POS) : longint'(shadow_entries[i+1]);
        if (hi < lo)
            return lo[DATA_W-1:0];
        span = hi - lo + 1;
        return DATA_W'(lo + longint'({$urandom, $urandom} % span));
    endfunction

    // Update the shadow state for an accepted transaction and queue its answer.
    task automatic note_accepted(input logic op, input logic [INDEX_W-1:0] idx,
                                 input logic signed [DATA_W-1:0] val, input logic typed,
                                 input logic hit, input logic [POS_W-1:0] pos);
        answer_t ans;
        if (op == OP_WRITE)
            shadow_entries[idx] = val;
        else
        begin
            if (typed)
            begin
                ans.hit = hit;
                ans.pos = pos;
            end
            else
                ans = lookup_key(val);
            pending_answers.push_back(ans);
        end
    endtask

    // Present one transaction, hold it until accepted, then maybe pause.
    // Busy only changes at a rising edge, so its value at the falling edge
    // decides whether the following rising edge accepts the transaction.
    task automatic issue(input logic op, input logic [INDEX_W-1:0] idx,
                         input logic signed [DATA_W-1:0] val, input logic typed,
                         input logic hit, input logic [POS_W-1:0] pos);
        start     <= 1'b1;
        operation <= op;
        index     <= idx;
        value     <= val;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        note_accepted(op, idx, val, typed, hit, pos);
        if (idling_on)
        begin
            while ($urandom_range(0, 99) < 19)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // Stop sending and wait until every search has answered.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic set_entry_count(input logic [COUNT_W-1:0] count);
        drain();
        repeat (4)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_count = count;
    endtask

    // Mostly keys that are stored, then near misses, random keys and extremes.
    task automatic random_search(input int span_n);
        logic signed [DATA_W-1:0] key;
        int                       r;
        r = $urandom_range(0, 99);
        if (span_n == 0 || r >= 92)
            key = $urandom;
        else if (r < 55)
            key = shadow_entries[$urandom_range(0, span_n - 1)];
        else if (r < 75)
            key = shadow_entries[$urandom_range(0, span_n - 1)]
                  + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
        else if (r < 85)
            key = $urandom;
        else
            key = $urandom_range(0, 1) ? MOST_POS : MOST_NEG;
        issue(OP_SEARCH, INDEX_W'($urandom), key, 1'b0, 1'b0, '0);
    endtask

    // Mostly order-preserving updates, with the odd value that breaks the order.
    task automatic random_write(input int limit);
        int                       idx;
        logic signed [DATA_W-1:0] val;
        idx = $urandom_range(0, limit - 1);
        if ($urandom_range(0, 99) < 8)
            val = $urandom;
        else
            val = value_between(idx);
        issue(OP_WRITE, INDEX_W'(idx), val, 1'b0, 1'b0, '0);
    endtask

    // Every strobed answer is checked against the oldest outstanding search.
    // The strobe lasts one whole cycle, so the falling edge sees it once.
    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("answer strobed with no search outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (found !== want.hit)
                begin
                    $error("found: expected %0b, got %0b", want.hit, found);
                    mismatch_count++;
                end
                if (position !== want.pos)
                begin
                    $error("position: expected %0d, got %0d", want.pos, position);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        int        order [DEPTH];
        longint    vals [DEPTH];
        longint    acc;
        int        phase_counts [N_PHASES];
        int        ph;
        int        k;
        int        j;
        int        tmp;
        int        n;
        int        c;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        for (k = 0; k < N_DIRECTED; k++)
        begin
            row = DIRECTED[k];
            if (row.kind == ROW_CONFIG)
                set_entry_count(row.val[COUNT_W-1:0]);
            else
                issue(row.op, row.idx, row.val, row.typed, row.hit, row.pos);
        end

        // Fill the whole table with ascending values, in shuffled order.
        acc = longint'(MOST_NEG) + $urandom_range(0, 1000);
        for (k = 0; k < DEPTH; k++)
        begin
            if (k > 0 && $urandom_range(0, 7) != 0)
                acc = acc + $urandom_range(1, 8_000_000);
            if (acc > longint'(MOST_POS))
                acc = longint'(MOST_POS);
            vals[k] = acc;
            order[k] = k;
        end
        for (k = DEPTH - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (k = 0; k < DEPTH; k++)
            issue(OP_WRITE, INDEX_W'(order[k]), vals[order[k]][DATA_W-1:0],
                  1'b0, 1'b0, '0);

        // Search phases over a range of entry counts, saturation included.
        phase_counts = '{1024, 2047, 1, 2, 3, $urandom_range(4, 63),
                         $urandom_range(64, 1023), $urandom_range(4, 1023),
                         $urandom_range(1025, 2046), $urandom_range(512, 1023), 1023};
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            set_entry_count(COUNT_W'(phase_counts[ph]));
            idling_on = !(ph == 3 || ph == 4);
            n = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 6 && k == PHASE_ITEMS / 2)
                    drain();
                if ($urandom_range(0, 99) < 15)
                    random_write(DEPTH);
                else
                    random_search(n);
            end
        end
        idling_on = 1'b1;

        // Short tables of small values with many duplicates, so keys hit often.
        for (ph = 0; ph < 2; ph++)
        begin
            c = $urandom_range(8, 40);
            acc = longint'($urandom_range(0, 6)) - 3;
            for (k = 0; k < c; k++)
            begin
                acc = acc + $urandom_range(0, 2);
                vals[k] = acc;
                order[k] = k;
            end
            for (k = c - 1; k > 0; k--)
            begin
                j = $urandom_range(0, k);
                tmp = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            for (k = 0; k < c; k++)
                issue(OP_WRITE, INDEX_W'(order[k]), vals[order[k]][DATA_W-1:0],
                      1'b0, 1'b0, '0);
            set_entry_count(COUNT_W'(c));
            for (k = 0; k < 35; k++)
            begin
                if ($urandom_range(0, 99) < 15)
                    random_write(c);
                else
                    issue(OP_SEARCH, INDEX_W'($urandom),
                          DATA_W'($urandom_range(0, 2 * c + 8) - 4), 1'b0, 1'b0, '0);
            end
        end

        // Let the last search answer, then allow for any late strobe.
        drain();
        repeat (30)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
